// File: src/voice_allocator_round_robin_steal_assert.svh
// Assertion macros shared by the voice allocator RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef VOICE_ALLOCATOR_ROUND_ROBIN_STEAL_ASSERT_SVH
`define VOICE_ALLOCATOR_ROUND_ROBIN_STEAL_ASSERT_SVH
`ifndef ASSERT_OFF
// Clocked check that is switched off while reset is asserted.
`define VARS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("voice allocator check failed");
// Clocked check that also holds across reset.
`define VARS_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("voice allocator reset check failed");
`else
`define VARS_ASSERT(lbl, clk, rstn, prop)
`define VARS_ASSERT_RST(lbl, clk, prop)
`endif
`endif

// File: src/vars_pkg.sv
// Shared constants, types and helper functions of the voice allocator.
// No dependencies; vars_scan and the top level import this package.
`default_nettype none

package vars_pkg;

    localparam int VOICES     = 16;
    localparam int VIDX_W     = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CNT_W      = VIDX_W + 1;
    localparam int TAG_W      = 16;
    localparam int AGE_W      = 64;
    localparam int NOTE_W     = 7;
    localparam int VEL_W      = 16;
    localparam int MEM_W      = TAG_W + AGE_W;
    localparam int S_TDATA_W  = 48;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 32;
    localparam int M_TUSER_W  = 2;

    typedef logic [VIDX_W-1:0] voice_idx_t;

    typedef enum logic [1:0] {
        FN_NOTE_ON    = 2'd0,
        FN_NOTE_OFF   = 2'd1,
        FN_VOICE_DONE = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ACT_START   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_NONE    = 2'd2
    } action_t;

    // Control from the sequencer to the scan unit.
    typedef struct packed {
        logic       clear;
        logic       eval;
        voice_idx_t idx;
    } scan_ctl_t;

    // Running results of one pass over the voice table.
    typedef struct packed {
        logic       hi_hit;
        voice_idx_t hi_idx;
        logic       lo_hit;
        voice_idx_t lo_idx;
        voice_idx_t best_idx;
        logic       match_hit;
        voice_idx_t match_idx;
    } scan_res_t;

    function automatic logic [3:0] voice_to_field(voice_idx_t v);
        logic [VIDX_W+3:0] w;
        w = (VIDX_W + 4)'(v);
        return w[3:0];
    endfunction

    function automatic voice_idx_t field_to_voice(logic [3:0] f);
        logic [VIDX_W+3:0] w;
        w = (VIDX_W + 4)'(f);
        return w[VIDX_W-1:0];
    endfunction

    function automatic logic voice_in_range(logic [3:0] f);
        return 7'(f) < 7'(VOICES);
    endfunction

    function automatic voice_idx_t voice_after(voice_idx_t v);
        voice_idx_t r;
        if (v == voice_idx_t'(VOICES - 1)) begin
            r = '0;
        end else begin
            r = v + 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/vars_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
// Generic; no package dependency.
`default_nettype none

module vars_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 80,
    parameter int ADDR_W = 4
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: src/vars_scan.sv
// Scan unit: folds one voice table entry per cycle into the free-voice,
// oldest-voice and tag-match results. Depends on vars_pkg.
`default_nettype none

module vars_scan (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire vars_pkg::scan_ctl_t       ctl,
    input  wire logic                      entry_active,
    input  wire vars_pkg::voice_idx_t      cursor,
    input  wire logic [vars_pkg::TAG_W-1:0] key_tag,
    input  wire logic [vars_pkg::MEM_W-1:0] rd_data,
    output vars_pkg::scan_res_t            res
);
    import vars_pkg::*;

    scan_res_t        res_reg, res_next;
    logic             best_vld_reg, best_vld_next;
    logic [AGE_W-1:0] best_age_reg, best_age_next;
    logic [TAG_W-1:0] ent_tag;
    logic [AGE_W-1:0] ent_age;

    assign ent_tag = rd_data[TAG_W-1:0];
    assign ent_age = rd_data[MEM_W-1:TAG_W];

    // Entries arrive in ascending order, so the first hit of each kind is the
    // lowest index. Free voices at or above the cursor win over those below it.
    always_comb begin
        res_next      = res_reg;
        best_vld_next = best_vld_reg;
        best_age_next = best_age_reg;
        if (ctl.clear) begin
            res_next.hi_hit    = 1'b0;
            res_next.lo_hit    = 1'b0;
            res_next.match_hit = 1'b0;
            best_vld_next      = 1'b0;
        end else if (ctl.eval) begin
            if (!entry_active && !res_reg.hi_hit && ctl.idx >= cursor) begin
                res_next.hi_hit = 1'b1;
                res_next.hi_idx = ctl.idx;
            end
            if (!entry_active && !res_reg.lo_hit && ctl.idx < cursor) begin
                res_next.lo_hit = 1'b1;
                res_next.lo_idx = ctl.idx;
            end
            if (!best_vld_reg || ent_age < best_age_reg) begin
                best_vld_next     = 1'b1;
                best_age_next     = ent_age;
                res_next.best_idx = ctl.idx;
            end
            if (entry_active && !res_reg.match_hit && ent_tag == key_tag) begin
                res_next.match_hit = 1'b1;
                res_next.match_idx = ctl.idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg.hi_hit    <= 1'b0;
            res_reg.lo_hit    <= 1'b0;
            res_reg.match_hit <= 1'b0;
            best_vld_reg      <= 1'b0;
        end else begin
            res_reg.hi_hit    <= res_next.hi_hit;
            res_reg.lo_hit    <= res_next.lo_hit;
            res_reg.match_hit <= res_next.match_hit;
            best_vld_reg      <= best_vld_next;
        end
        res_reg.hi_idx    <= res_next.hi_idx;
        res_reg.lo_idx    <= res_next.lo_idx;
        res_reg.best_idx  <= res_next.best_idx;
        res_reg.match_idx <= res_next.match_idx;
        best_age_reg      <= best_age_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// File: src/voice_allocator_round_robin_steal.sv
// Top level of the round-robin voice allocator with oldest-voice stealing.
// Depends on vars_pkg, vars_ram, vars_scan and the assertion macro header.
//
// Usage: one transfer on the s_ channel carries an event (note on, note off,
// voice done) and always produces exactly one result transfer on the m_
// channel (start, release or nothing to do). Items are handled one at a time.
// Note on and note off read the tag/age table once per voice, one entry per
// cycle from a RAM with a registered read port; the next item is accepted
// only after the result has been loaded into the output register.
// A voice-done or unknown event skips the scan and has its result loaded
// as soon as the output register is free.
// The result waits in an output register; s_tready rises again while that
// result is still pending, and a stalled m_ channel only holds up the
// following result, not the scan.
// Reset (aresetn low, synchronous) clears all active marks, the cursor, the
// age counter and the output valid; the tag/age table needs no clearing since
// an entry is only consulted while its active mark is set.
`default_nettype none
`include "voice_allocator_round_robin_steal_assert.svh"

module voice_allocator_round_robin_steal (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [6:0] note, [22:7] velocity, [38:23] voice_tag, [42:39] voice_index
    input  wire logic [vars_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] func
    input  wire logic [vars_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [3:0] chosen_voice, [4] stolen, [11:5] start_note, [27:12] start_velocity
    output logic      [vars_pkg::M_TDATA_W-1:0] m_tdata,
    // [1:0] action
    output logic      [vars_pkg::M_TUSER_W-1:0] m_tuser
);
    import vars_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [VOICES-1:0]       active_reg, active_next;
    voice_idx_t              cursor_reg, cursor_next;
    logic [AGE_W-1:0]        age_reg, age_next;

    logic [1:0]              job_func_reg;
    logic [NOTE_W-1:0]       job_note_reg;
    logic [VEL_W-1:0]        job_vel_reg;
    logic [TAG_W-1:0]        job_tag_reg;
    logic [3:0]              job_vidx_reg;

    logic                    out_vld_reg, out_vld_next;
    logic [M_TDATA_W-1:0]    out_data_reg;
    logic [M_TUSER_W-1:0]    out_user_reg;

    logic                    in_xfer;
    logic                    finish;
    logic                    fin_on;
    scan_ctl_t               scan_ctl;
    scan_res_t               scan_res;
    logic [MEM_W-1:0]        rd_data;
    logic [CNT_W-1:0]        cnt_prev;
    voice_idx_t              on_voice;
    logic                    on_stolen;
    action_t                 res_action;
    voice_idx_t              res_voice;
    logic                    res_stolen;
    logic [NOTE_W-1:0]       res_note;
    logic [VEL_W-1:0]        res_vel;
    voice_idx_t              done_voice;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign finish   = (state_reg == ST_DONE) && (!out_vld_reg || m_tready);
    assign fin_on   = finish && (job_func_reg == FN_NOTE_ON);
    assign cnt_prev = cnt_reg - 1'b1;

    // The RAM read is registered, so the entry being folded in is always the
    // counter minus one.
    always_comb begin
        scan_ctl.clear = in_xfer;
        scan_ctl.eval  = (state_reg == ST_SCAN) && (cnt_reg != '0);
        scan_ctl.idx   = cnt_prev[VIDX_W-1:0];
    end

    vars_ram #(
        .DEPTH  (VOICES),
        .WIDTH  (MEM_W),
        .ADDR_W (VIDX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (fin_on),
        .wr_addr (on_voice),
        .wr_data ({age_reg, job_tag_reg}),
        .rd_addr (cnt_reg[VIDX_W-1:0]),
        .rd_data (rd_data)
    );

    vars_scan u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (scan_ctl),
        .entry_active (active_reg[scan_ctl.idx]),
        .cursor       (cursor_reg),
        .key_tag      (job_tag_reg),
        .rd_data      (rd_data),
        .res          (scan_res)
    );

    always_comb begin
        if (scan_res.hi_hit) begin
            on_voice  = scan_res.hi_idx;
            on_stolen = 1'b0;
        end else if (scan_res.lo_hit) begin
            on_voice  = scan_res.lo_idx;
            on_stolen = 1'b0;
        end else begin
            on_voice  = scan_res.best_idx;
            on_stolen = 1'b1;
        end
    end

    assign done_voice = field_to_voice(job_vidx_reg);

    always_comb begin
        res_action = ACT_NONE;
        res_voice  = '0;
        res_stolen = 1'b0;
        res_note   = '0;
        res_vel    = '0;
        case (job_func_reg)
            FN_NOTE_ON: begin
                res_action = ACT_START;
                res_voice  = on_voice;
                res_stolen = on_stolen;
                res_note   = job_note_reg;
                res_vel    = job_vel_reg;
            end
            FN_NOTE_OFF: begin
                if (scan_res.match_hit) begin
                    res_action = ACT_RELEASE;
                    res_voice  = scan_res.match_idx;
                end
            end
            default: begin
                res_action = ACT_NONE;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        active_next  = active_reg;
        cursor_next  = cursor_reg;
        age_next     = age_reg;
        out_vld_next = out_vld_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (in_xfer) begin
                    if (s_tuser == FN_NOTE_ON || s_tuser == FN_NOTE_OFF) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(VOICES)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (finish) begin
                    state_next   = ST_IDLE;
                    out_vld_next = 1'b1;
                    if (job_func_reg == FN_NOTE_ON) begin
                        active_next[on_voice] = 1'b1;
                        cursor_next           = voice_after(on_voice);
                        age_next              = age_reg + 1'b1;
                    end else if (job_func_reg == FN_VOICE_DONE &&
                                 voice_in_range(job_vidx_reg)) begin
                        active_next[done_voice] = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            active_reg  <= '0;
            cursor_reg  <= '0;
            age_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            active_reg  <= active_next;
            cursor_reg  <= cursor_next;
            age_reg     <= age_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            job_func_reg <= s_tuser[1:0];
            job_note_reg <= s_tdata[6:0];
            job_vel_reg  <= s_tdata[22:7];
            job_tag_reg  <= s_tdata[38:23];
            job_vidx_reg <= s_tdata[42:39];
        end
        if (finish) begin
            out_user_reg <= res_action;
            out_data_reg <= {4'b0000, res_vel, res_note, res_stolen,
                             voice_to_field(res_voice)};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    `VARS_ASSERT(a_one_item_at_a_time, aclk, aresetn, in_xfer |=> !s_tready)
    `VARS_ASSERT(a_age_steps_on_start, aclk, aresetn, fin_on |=> (age_reg == $past(age_reg) + 1'b1))
    `VARS_ASSERT(a_started_voice_active, aclk, aresetn, fin_on |=> (active_reg[$past(on_voice)] == 1'b1))
    `VARS_ASSERT(a_result_loaded_on_finish, aclk, aresetn, finish |=> (m_tvalid && s_tready))
    `VARS_ASSERT_RST(a_reset_clears_output, aclk, !aresetn |=> (!m_tvalid && cursor_reg == '0))

endmodule

`default_nettype wire

// File: sim/voice_allocator_checker.sv
// Checker for the voice allocator: watches both stream channels, predicts each result
// from its own copy of the voice table, and compares the results in order.
// Depends on vars_pkg for the widths and the function and action codes.
module voice_allocator_checker (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    input  wire logic                             s_tready,
    input  wire logic [vars_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [vars_pkg::S_TUSER_W-1:0]   s_tuser,
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [vars_pkg::M_TDATA_W-1:0]   m_tdata,
    input  wire logic [vars_pkg::M_TUSER_W-1:0]   m_tuser,
    output int                                    fail_count,
    output int                                    pending
);
    import vars_pkg::*;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  voice;
        logic        stolen;
        logic [6:0]  note;
        logic [15:0] velocity;
    } voice_result_t;

    logic        voice_busy [VOICES];
    logic [15:0] voice_tag [VOICES];
    logic [63:0] voice_age [VOICES];
    int          rr_cursor;
    logic [63:0] age_next;

    voice_result_t expected_q[$];

    // Applies one event to the voice table and returns the result it must produce.
    function automatic voice_result_t allocate(logic [1:0] func, logic [6:0] note,
                                               logic [15:0] velocity, logic [15:0] tag,
                                               logic [3:0] done_idx);
        voice_result_t r;
        int            v;
        int            k;
        logic          found;
        r        = '0;
        r.action = ACT_NONE;
        found    = 1'b0;
        v        = 0;
        case (func)
            FN_NOTE_ON: begin
                for (k = 0; k < VOICES; k++) begin
                    if (!found && !voice_busy[(rr_cursor + k) % VOICES]) begin
                        found = 1'b1;
                        v     = (rr_cursor + k) % VOICES;
                    end
                end
                // Every voice busy: the oldest stamp loses, lowest index on a tie.
                if (!found) begin
                    for (k = 1; k < VOICES; k++) begin
                        if (voice_age[k] < voice_age[v]) v = k;
                    end
                end
                rr_cursor     = (v + 1) % VOICES;
                voice_tag[v]  = tag;
                voice_age[v]  = age_next;
                age_next      = age_next + 64'd1;
                voice_busy[v] = 1'b1;
                r.action      = ACT_START;
                r.voice       = 4'(v);
                r.stolen      = !found;
                r.note        = note;
                r.velocity    = velocity;
            end
            FN_NOTE_OFF: begin
                for (k = 0; k < VOICES; k++) begin
                    if (!found && voice_busy[k] && voice_tag[k] == tag) begin
                        found    = 1'b1;
                        r.action = ACT_RELEASE;
                        r.voice  = 4'(k);
                    end
                end
            end
            FN_VOICE_DONE: begin
                if (int'(done_idx) < VOICES) voice_busy[done_idx] = 1'b0;
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        voice_result_t exp_r;
        voice_result_t got_r;
        if (!aresetn) begin
            for (int k = 0; k < VOICES; k++) begin
                voice_busy[k] = 1'b0;
                voice_tag[k]  = '0;
                voice_age[k]  = '0;
            end
            rr_cursor = 0;
            age_next  = '0;
            expected_q.delete();
            fail_count <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_q.push_back(allocate(s_tuser, s_tdata[6:0], s_tdata[22:7],
                                              s_tdata[38:23], s_tdata[42:39]));
            end
            if (m_tvalid && m_tready) begin
                got_r.action   = m_tuser[1:0];
                got_r.voice    = m_tdata[3:0];
                got_r.stolen   = m_tdata[4];
                got_r.note     = m_tdata[11:5];
                got_r.velocity = m_tdata[27:12];
                if (expected_q.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("voice allocator: result transfer with none expected: %s",
                                 $sformatf("action %0d voice %0d",
                                           got_r.action, got_r.voice));
                    end
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got_r.action !== exp_r.action || got_r.voice !== exp_r.voice ||
                        got_r.stolen !== exp_r.stolen || got_r.note !== exp_r.note ||
                        got_r.velocity !== exp_r.velocity) begin
                        if (fail_count < 10) begin
                            $display("voice allocator mismatch: expected %s",
                                     $sformatf("action %0d voice %0d stolen %0b note %0d vel %0d",
                                               exp_r.action, exp_r.voice, exp_r.stolen,
                                               exp_r.note, exp_r.velocity));
                            $display("                          got      %s",
                                     $sformatf("action %0d voice %0d stolen %0b note %0d vel %0d",
                                               got_r.action, got_r.voice, got_r.stolen,
                                               got_r.note, got_r.velocity));
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending <= expected_q.size();
    end

endmodule

// File: sim/tb_voice_allocator_round_robin_steal.sv
// Testbench top for the voice allocator: clock, reset, event stimulus and the verdict.
// Depends on vars_pkg, the allocator RTL and voice_allocator_checker.
module tb_voice_allocator_round_robin_steal;
    import vars_pkg::*;

    localparam logic [1:0] FN_UNUSED      = 2'd3;
    localparam int         ITEM_TARGET    = 1300;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         DRAIN_CYCLES   = 60;
    localparam int         HOLD_CYCLES    = 300;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    int fail_count;
    int pending;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int rx_hold_req  = 0;
    int idle_cycles  = 0;
    int items_sent   = 0;

    logic [15:0] live_tags[$];

    always #4 aclk = ~aclk;

    voice_allocator_round_robin_steal DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    voice_allocator_checker u_alloc_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Result side: random back-pressure, plus a long hold-off when one is requested.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req > 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_voice_allocator_round_robin_steal NOT OK");
                $finish;
            end
        end
    end

    // Offers one event and returns at the edge where its transfer happens.
    task automatic offer_event(logic [1:0] func, logic [6:0] note, logic [15:0] velocity,
                               logic [15:0] tag, logic [3:0] done_idx);
        int gap;
        if ($urandom_range(99) < tx_idle_pct) begin
            gap = $urandom_range(1, 4);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, done_idx, tag, velocity, note};
        s_tuser  <= func;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_all_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic note_on_random();
        logic [15:0] tag;
        if ($urandom_range(3) == 0) tag = 16'($urandom_range(0, 7));
        else tag = 16'($urandom_range(0, 65535));
        live_tags.push_back(tag);
        if (live_tags.size() > 24) void'(live_tags.pop_front());
        offer_event(FN_NOTE_ON, 7'($urandom_range(0, 127)), 16'($urandom_range(0, 65535)),
                    tag, 4'($urandom_range(0, 15)));
    endtask

    // Mostly releases of tags still in play; the rest are stray tags.
    task automatic note_off_random();
        logic [15:0] tag;
        int          pick;
        if (live_tags.size() > 0 && $urandom_range(9) < 8) begin
            pick = $urandom_range(0, live_tags.size() - 1);
            tag  = live_tags[pick];
            live_tags.delete(pick);
        end else begin
            tag = 16'($urandom_range(0, 65535));
        end
        offer_event(FN_NOTE_OFF, 7'($urandom_range(0, 127)), 16'($urandom_range(0, 65535)),
                    tag, 4'($urandom_range(0, 15)));
    endtask

    task automatic run_random(int count);
        int done_here;
        int on_weight;
        int r;
        done_here = 0;
        on_weight = 40;
        while (done_here < count) begin
            if (done_here % 40 == 0) on_weight = $urandom_range(25, 60);
            r = $urandom_range(99);
            if (r < on_weight) begin
                note_on_random();
            end else if (r < on_weight + 25) begin
                note_off_random();
            end else if (r < 97) begin
                offer_event(FN_VOICE_DONE, 7'($urandom_range(0, 127)),
                            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                            4'($urandom_range(0, 15)));
            end else begin
                offer_event(FN_UNUSED, 7'($urandom_range(0, 127)),
                            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                            4'($urandom_range(0, 15)));
            end
            // Events of the unused code only get a nothing-to-do result and do not count.
            if (r < 97) begin
                done_here  = done_here + 1;
                items_sent = items_sent + 1;
            end
        end
    endtask

    initial begin : stimulus
        int per_phase;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 6;
        rx_idle_pct = 75;

        // Empty table: releases and done events find nothing.
        offer_event(FN_NOTE_OFF, 7'd0, 16'h0000, 16'h0000, 4'd0);
        offer_event(FN_VOICE_DONE, 7'd0, 16'h0000, 16'h0000, 4'd15);
        offer_event(FN_UNUSED, 7'h7F, 16'hFFFF, 16'hFFFF, 4'hF);
        offer_event(FN_NOTE_ON, 7'd0, 16'h0000, 16'h0000, 4'd0);
        offer_event(FN_NOTE_ON, 7'h7F, 16'hFFFF, 16'hFFFF, 4'hF);
        offer_event(FN_NOTE_OFF, 7'd0, 16'h0000, 16'hFFFF, 4'd0);
        offer_event(FN_NOTE_OFF, 7'd0, 16'h0000, 16'h5A5A, 4'd0);
        offer_event(FN_VOICE_DONE, 7'd0, 16'h0000, 16'h0000, 4'd1);
        // The released voice is now finished, so its tag no longer matches.
        offer_event(FN_NOTE_OFF, 7'd0, 16'h0000, 16'hFFFF, 4'd0);
        // Fill every voice, then one more note on steals the oldest one.
        for (int k = 0; k < 16; k++) begin
            offer_event(FN_NOTE_ON, 7'(k * 8), 16'(k * 4096 + 1),
                        (k % 2 == 1) ? 16'h00AA : 16'(k), 4'(k));
        end
        // Several voices share this tag; the lowest numbered one is released.
        offer_event(FN_NOTE_OFF, 7'd0, 16'h0000, 16'h00AA, 4'd0);
        items_sent = 25;
        wait_all_results();

        per_phase = (ITEM_TARGET - items_sent) / 3;
        run_random(per_phase);
        wait_all_results();

        tx_idle_pct = 75;
        rx_idle_pct = 6;
        run_random(per_phase);
        wait_all_results();

        // No idling, and a long hold-off on the result side while events keep coming.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_req = HOLD_CYCLES;
        run_random(ITEM_TARGET - items_sent);

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_voice_allocator_round_robin_steal OK");
        end else begin
            $display("tb_voice_allocator_round_robin_steal NOT OK");
        end
        $finish;
    end

endmodule

// File: voice_allocator_round_robin_steal.f
+incdir+src
src/vars_pkg.sv
src/vars_ram.sv
src/vars_scan.sv
src/voice_allocator_round_robin_steal.sv
sim/voice_allocator_checker.sv
sim/tb_voice_allocator_round_robin_steal.sv
